/* hdl/epcw_pkg.sv */
// Shared types, codes and helpers of the extended partition chain walker.
`default_nettype none
package epcw_pkg;

   localparam int RESULTS_MAX = 3;

   localparam logic [2:0] KIND_REGION = 3'd0;
   localparam logic [2:0] KIND_FETCH  = 3'd1;
   localparam logic [2:0] KIND_DONE   = 3'd2;
   localparam logic [2:0] KIND_ERROR  = 3'd3;
   localparam logic [2:0] KIND_IDLE   = 3'd4;

   localparam logic [2:0] CAUSE_NONE      = 3'd0;
   localparam logic [2:0] CAUSE_STATUS    = 3'd1;
   localparam logic [2:0] CAUSE_SIGNATURE = 3'd2;
   localparam logic [2:0] CAUSE_OUTSIDE   = 3'd3;
   localparam logic [2:0] CAUSE_TWO_LINKS = 3'd4;
   localparam logic [2:0] CAUSE_EXTRA     = 3'd5;

   localparam logic [7:0] PTYPE_EMPTY = 8'h00;
   localparam logic [7:0] PTYPE_LINK  = 8'h05;
   localparam logic [7:0] STATUS_IDLE = 8'h00;
   localparam logic [7:0] STATUS_BOOT = 8'h80;
   localparam logic [15:0] SIG_OK     = 16'h55AA;

   localparam logic [15:0] MAX_PART_RESET = 16'd50;

   localparam logic [1:0] REG_EXT_START = 2'd0;
   localparam logic [1:0] REG_EXT_SIZE  = 2'd1;
   localparam logic [1:0] REG_MAX_PART  = 2'd2;
   localparam logic [1:0] REG_START_CNT = 2'd3;

   typedef struct packed {
      logic [7:0]  first_status;
      logic [7:0]  first_type;
      logic [31:0] first_start;
      logic [31:0] first_count;
      logic [7:0]  second_status;
      logic [7:0]  second_type;
      logic [31:0] second_start;
      logic [31:0] second_count;
      logic [7:0]  third_type;
      logic [7:0]  fourth_type;
      logic [15:0] record_signature;
   } record_type;

   typedef struct packed {
      logic [31:0] ext_start_lba;
      logic [31:0] ext_size_lba;
      logic [15:0] max_partitions;
   } cfg_type;

   typedef struct packed {
      logic [31:0] link_offset;
      logic [15:0] partition_count;
      logic        armed;
   } walk_state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [32:0] region_start;
      logic [31:0] region_length;
      logic [2:0]  error_cause;
      logic        last;
   } result_type;

   function automatic result_type mk_result(input logic [2:0] kind,
                                            input logic [32:0] start,
                                            input logic [31:0] len,
                                            input logic [2:0] cause,
                                            input logic last);
      result_type r;
      r.kind          = kind;
      r.region_start  = start;
      r.region_length = len;
      r.error_cause   = cause;
      r.last          = last;
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/epcw_eval.sv */
// Evaluation of one boot record: checks, entry rules, result list and next walk state.
`default_nettype none
module epcw_eval
   import epcw_pkg::*;
(
   input  wire record_type     rec,
   input  wire cfg_type        cfg,
   input  wire walk_state_type st,
   output result_type          slots [RESULTS_MAX],
   output logic [1:0]          slot_count,
   output walk_state_type      st_next
);

   logic        t0_empty, t0_link, t0_part;
   logic        t1_empty, t1_link, t1_part;
   logic        status_bad;
   logic [15:0] pc_inc;
   logic [32:0] limit;
   logic [33:0] rs0, rs1;
   logic [34:0] end0, end1;
   logic        over0, over1;
   logic [31:0] base1, off1;
   logic [32:0] fetch_start;
   result_type  cand [RESULTS_MAX];
   logic [RESULTS_MAX-1:0] cv;
   logic        stop;

   assign t0_empty = (rec.first_type == PTYPE_EMPTY);
   assign t0_link  = (rec.first_type == PTYPE_LINK);
   assign t0_part  = !t0_empty && !t0_link;
   assign t1_empty = (rec.second_type == PTYPE_EMPTY);
   assign t1_link  = (rec.second_type == PTYPE_LINK);
   assign t1_part  = !t1_empty && !t1_link;

   assign status_bad = !(rec.first_status inside {STATUS_IDLE, STATUS_BOOT}) ||
                       !(rec.second_status inside {STATUS_IDLE, STATUS_BOOT});

   assign pc_inc = (st.partition_count == 16'hFFFF) ? st.partition_count
                                                    : st.partition_count + 16'd1;

   assign limit = {1'b0, cfg.ext_start_lba} + {1'b0, cfg.ext_size_lba};

   // entry 0 region uses the incoming link offset
   assign rs0   = {2'b0, cfg.ext_start_lba} + {2'b0, st.link_offset} + {2'b0, rec.first_start};
   assign end0  = {1'b0, rs0} + {3'b0, rec.first_count};
   assign over0 = end0 > {2'b0, limit};

   // after entry 0 the offset is the link start if entry 0 linked, else cleared
   assign base1 = t0_link ? rec.first_start : 32'd0;
   assign rs1   = {2'b0, cfg.ext_start_lba} + {2'b0, base1} + {2'b0, rec.second_start};
   assign end1  = {1'b0, rs1} + {3'b0, rec.second_count};
   assign over1 = end1 > {2'b0, limit};

   assign off1        = t1_link ? rec.second_start : base1;
   assign fetch_start = {1'b0, cfg.ext_start_lba} + {1'b0, off1};

   always_comb begin
      for (int i = 0; i < RESULTS_MAX; i++) begin
         slots[i] = '0;
         cand[i]  = '0;
      end
      cv         = '0;
      stop       = 1'b0;
      slot_count = 2'd0;
      st_next    = st;
      if (!st.armed) begin
         slots[0]   = mk_result(KIND_IDLE, 33'd0, 32'd0, CAUSE_NONE, 1'b1);
         slot_count = 2'd1;
      end else if (status_bad) begin
         slots[0]      = mk_result(KIND_ERROR, 33'd0, 32'd0, CAUSE_STATUS, 1'b1);
         slot_count    = 2'd1;
         st_next.armed = 1'b0;
      end else if (rec.record_signature != SIG_OK) begin
         slots[0]      = mk_result(KIND_ERROR, 33'd0, 32'd0, CAUSE_SIGNATURE, 1'b1);
         slot_count    = 2'd1;
         st_next.armed = 1'b0;
      end else begin
         st_next.partition_count = pc_inc;
         if (t0_part) begin
            cv[0] = 1'b1;
            if (over0) begin
               cand[0] = mk_result(KIND_ERROR, 33'd0, 32'd0, CAUSE_OUTSIDE, 1'b1);
               stop    = 1'b1;
            end else begin
               cand[0] = mk_result(KIND_REGION, rs0[32:0], rec.first_count, CAUSE_NONE, 1'b0);
            end
         end
         if (!stop) begin
            if (t1_link && t0_link) begin
               cv[1]   = 1'b1;
               cand[1] = mk_result(KIND_ERROR, 33'd0, 32'd0, CAUSE_TWO_LINKS, 1'b1);
               stop    = 1'b1;
            end else if (t1_part) begin
               cv[1] = 1'b1;
               if (over1) begin
                  cand[1] = mk_result(KIND_ERROR, 33'd0, 32'd0, CAUSE_OUTSIDE, 1'b1);
                  stop    = 1'b1;
               end else begin
                  cand[1] = mk_result(KIND_REGION, rs1[32:0], rec.second_count,
                                      CAUSE_NONE, 1'b0);
               end
            end
         end
         if (!stop) begin
            cv[2] = 1'b1;
            if (rec.third_type != PTYPE_EMPTY || rec.fourth_type != PTYPE_EMPTY) begin
               cand[2] = mk_result(KIND_ERROR, 33'd0, 32'd0, CAUSE_EXTRA, 1'b1);
               stop    = 1'b1;
            end else if (off1 != 32'd0 && pc_inc < cfg.max_partitions) begin
               cand[2] = mk_result(KIND_FETCH, fetch_start, 32'd0, CAUSE_NONE, 1'b1);
               st_next.link_offset = off1;
            end else begin
               cand[2] = mk_result(KIND_DONE, 33'd0, 32'd0, CAUSE_NONE, 1'b1);
               stop    = 1'b1;
            end
         end
         if (stop) st_next.armed = 1'b0;
         for (int i = 0; i < RESULTS_MAX; i++) begin
            if (cv[i]) begin
               slots[slot_count] = cand[i];
               slot_count        = slot_count + 2'd1;
            end
         end
      end
   end

endmodule
`default_nettype wire

/* hdl/epcw_rsp_queue.sv */
// Result queue: holds the results of one record and drains them one per transaction.
`default_nettype none
module epcw_rsp_queue
   import epcw_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         load,
   input  wire result_type load_slots [RESULTS_MAX],
   input  wire  [1:0]  load_count,
   output logic        can_load,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output result_type  rsp_head,
   output logic [1:0]  pending
);

   result_type slots_ff [RESULTS_MAX];
   result_type slots_in [RESULTS_MAX];
   logic [1:0] cnt_ff, cnt_in;
   logic       take;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign take       = rsp_tvalid && rsp_tready;
   assign can_load   = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign rsp_head   = slots_ff[0];
   assign pending    = cnt_ff;

   always_comb begin
      slots_in = slots_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         slots_in = load_slots;
         cnt_in   = load_count;
      end else if (take) begin
         for (int i = 0; i < RESULTS_MAX - 1; i++) slots_in[i] = slots_ff[i+1];
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/extended_partition_chain_walker_unit.sv */
// Top level of the extended partition chain walker: input register, state, config, results.
// Path: a record accepted into the input register is evaluated there and loaded into the
//   result queue, which presents its first result; the load waits while the queue cannot take it.
// Throughput: one record per cycle when it yields one result and rsp_tready stays high; a
//   record with k results (at most three) holds the result queue until all k are taken.
// Reset: synchronous, active high; clears the link offset and partition count, arms the
//   walk and loads register defaults (maximum partition count 50, others zero).
`default_nettype none
module extended_partition_chain_walker_unit
   import epcw_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // first_status, first_type, first_start, first_count, second_status, second_type,
   // second_start, second_count, third_type, fourth_type, record_signature
   input  wire  [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // region_start, region_length, error_cause, zero pad
   output logic [71:0]  rsp_tdata,
   // kind
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  wire          csr_we,
   input  wire  [1:0]   csr_index,
   input  wire  [31:0]  csr_wdata
);

   record_type     rec_ff, rec_in;
   logic           in_valid_ff, in_valid_in;
   cfg_type        cfg_ff, cfg_in;
   walk_state_type st_ff, st_in, st_eval;
   result_type     eval_slots [RESULTS_MAX];
   logic [1:0]     eval_count;
   logic           can_load, load;
   result_type     head;
   logic [1:0]     pending;

   assign load       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || load;

   always_comb begin
      rec_in                  = rec_ff;
      rec_in.first_status     = req_tdata[7:0];
      rec_in.first_type       = req_tdata[15:8];
      rec_in.first_start      = req_tdata[47:16];
      rec_in.first_count      = req_tdata[79:48];
      rec_in.second_status    = req_tdata[87:80];
      rec_in.second_type      = req_tdata[95:88];
      rec_in.second_start     = req_tdata[127:96];
      rec_in.second_count     = req_tdata[159:128];
      rec_in.third_type       = req_tdata[167:160];
      rec_in.fourth_type      = req_tdata[175:168];
      rec_in.record_signature = req_tdata[191:176];
      if (!(req_tvalid && req_tready)) rec_in = rec_ff;
   end

   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !load);

   epcw_eval u_eval (
      .rec        (rec_ff),
      .cfg        (cfg_ff),
      .st         (st_ff),
      .slots      (eval_slots),
      .slot_count (eval_count),
      .st_next    (st_eval)
   );

   always_comb begin
      cfg_in = cfg_ff;
      st_in  = load ? st_eval : st_ff;
      if (csr_we) begin
         case (csr_index)
            REG_EXT_START: cfg_in.ext_start_lba  = csr_wdata;
            REG_EXT_SIZE:  cfg_in.ext_size_lba   = csr_wdata;
            REG_MAX_PART:  cfg_in.max_partitions = csr_wdata[15:0];
            REG_START_CNT: begin
               st_in.partition_count = csr_wdata[15:0];
               st_in.link_offset     = 32'd0;
               st_in.armed           = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         in_valid_ff           <= 1'b0;
         cfg_ff.ext_start_lba  <= 32'd0;
         cfg_ff.ext_size_lba   <= 32'd0;
         cfg_ff.max_partitions <= MAX_PART_RESET;
         st_ff.link_offset     <= 32'd0;
         st_ff.partition_count <= 16'd0;
         st_ff.armed           <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
         st_ff       <= st_in;
      end
   end

   epcw_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_slots (eval_slots),
      .load_count (eval_count),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (head),
      .pending    (pending)
   );

   assign rsp_tdata = {4'd0, head.error_cause, head.region_length, head.region_start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // a non-final result always has its successor queued behind it
   a_nonlast_has_more: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> pending >= 2'd2)
      else $error("non-final result without a queued successor");

   a_nonlast_is_region: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == KIND_REGION)
      else $error("only scan regions may be non-final");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_we) && !$past(reset) |->
         st_ff.partition_count >= $past(st_ff.partition_count))
      else $error("partition count decreased without a register write");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      pending >= 2'd2 |-> !load)
      else $error("result queue overwritten while results pending");

endmodule
`default_nettype wire
